[src/fqps_pkg.sv]
package fqps_pkg;

  localparam int MAX_LEN_DEF = 1024;

  // characters that steer the parser
  localparam logic [7:0] CH_NL   = 8'd10;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  localparam logic [2:0] CLASS_NONE = 3'd5;
  localparam logic [2:0] SEL_QSUM   = 3'd5;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_READ = 2'd2,
    KIND_RD3  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STS_TAKEN     = 3'd0,
    STS_COMMIT    = 3'd1,
    STS_MALFORMED = 3'd2,
    STS_END       = 3'd3,
    STS_STAT      = 3'd4,
    STS_IGNORED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_SEEK   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SEQ    = 3'd2,
    PH_PLUS   = 3'd3,
    PH_QUAL   = 3'd4,
    PH_HALT   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_STAT  = 3'd2,
    ST_WALK  = 3'd3,
    ST_WLAST = 3'd4
  } ctrl_t;

  localparam logic REG_ACTIVE_LEN = 1'b0;
  localparam logic REG_REC_LIMIT  = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [9:0] position;
    logic [2:0] stat_select;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] record_count;
    logic [39:0] stat_value;
  } out_req_t;

  // one statistics row: five base counters and the quality sum
  typedef struct packed {
    logic [4:0][31:0] cnt;
    logic [39:0]      qsum;
  } stat_row_t;

  function automatic logic [2:0] classify(input logic [7:0] b);
    logic [2:0] c;
    case (b)
      8'h41, 8'h61: c = 3'd0;
      8'h54, 8'h74: c = 3'd1;
      8'h47, 8'h67: c = 3'd2;
      8'h43, 8'h63: c = 3'd3;
      8'h4E, 8'h6E: c = 3'd4;
      default:      c = CLASS_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

[src/fastq_record_position_stats.sv]
// fastq per-position statistics, one request in flight, the next taken as its result leaves
// text byte / end of stream: result registered, valid in the cycle after the request is taken
// stat read: the row is read from the statistics memory, then the result is registered in ST_STAT
// record commit: rows 0 to n-1 are updated, n = min(sequence length, active_length, MAX_LEN),
//   by the read-modify-write walk (ST_WALK, then ST_WLAST) over the statistics memory, one row a cycle
// reset: synchronous; then a clearing pass over all MAX_LEN rows with no request taken
module fastq_record_position_stats #(
  parameter int MAX_LEN = fqps_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fqps_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fqps_pkg::out_req_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import fqps_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [31:0] MAXL = 32'(MAX_LEN);

  // memories
  stat_row_t  stat_mem [MAX_LEN];
  logic [2:0] cls_mem  [MAX_LEN];
  logic [7:0] qb_mem   [MAX_LEN];

  ctrl_t       st_r, st_nxt;
  phase_t      ph_r, ph_nxt;
  logic        ls_r, ls_nxt;
  logic [31:0] seq_r, seq_nxt, ql_r, ql_nxt, rec_r, rec_nxt;
  logic [10:0] alen_r;
  logic [31:0] limit_r;
  logic [LW-1:0] idx_r, idx_nxt, n_r, n_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          wv_r, wv_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic [2:0]    sel_r, sel_nxt;
  logic          pok_r, pok_nxt;
  logic          ov_r, ov_nxt;
  out_req_t      od_r, od_nxt;

  logic [AW-1:0] rd_addr;
  stat_row_t     row_q, row_w;
  logic [2:0]    cls_q;
  logic [7:0]    qb_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic          cb_we, qb_we;
  logic [AW-1:0] buf_wa;
  logic          acc;
  logic [31:0]   lim, ncalc, pos_ext;
  logic [40:0]   qs_add;

  assign in_ready  = (st_r == ST_IDLE) && (!ov_r || out_ready);
  assign acc       = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign pos_ext   = {22'd0, in_data.position};

  // commit length
  always_comb begin
    lim   = ({21'd0, alen_r} > MAXL) ? MAXL : {21'd0, alen_r};
    ncalc = (seq_r < lim) ? seq_r : lim;
  end

  // modified statistics row
  always_comb begin
    row_w = row_q;
    for (int k = 0; k < 5; k++) begin
      if (cls_q == 3'(k)) row_w.cnt[k] = sat_inc32(row_q.cnt[k]);
    end
    qs_add = {1'b0, row_q.qsum} + {33'd0, qb_q};
    row_w.qsum = qs_add[40] ? 40'hFF_FFFF_FFFF : qs_add[39:0];
  end

  // control and parser
  always_comb begin
    st_nxt  = st_r;
    ph_nxt  = ph_r;
    ls_nxt  = ls_r;
    seq_nxt = seq_r;
    ql_nxt  = ql_r;
    rec_nxt = rec_r;
    idx_nxt = idx_r;
    n_nxt   = n_r;
    clr_nxt = clr_r;
    wv_nxt  = 1'b0;
    wa_nxt  = wa_r;
    sel_nxt = sel_r;
    pok_nxt = pok_r;
    ov_nxt  = ov_r && !out_ready;
    od_nxt  = od_r;
    rd_addr = pos_ext[AW-1:0];
    cb_we   = 1'b0;
    qb_we   = 1'b0;
    buf_wa  = seq_r[AW-1:0];
    case (st_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_LEN - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          od_nxt.status       = STS_TAKEN;
          od_nxt.record_count = rec_r;
          od_nxt.stat_value   = 40'd0;
          ov_nxt              = 1'b1;
          if (in_data.kind[1]) begin
            ov_nxt  = 1'b0;
            sel_nxt = in_data.stat_select;
            pok_nxt = pos_ext < MAXL;
            st_nxt  = ST_STAT;
          end else if (ph_r == PH_HALT) begin
            od_nxt.status = STS_IGNORED;
          end else if ((limit_r != 32'd0 && rec_r >= limit_r) ||
                       in_data.kind == KIND_END) begin
            ph_nxt        = PH_HALT;
            od_nxt.status = STS_END;
          end else begin
            case (ph_r)
              PH_SEEK: begin
                if (ls_r && in_data.byte_value == CH_AT) begin
                  ph_nxt = PH_HEADER;
                  ls_nxt = 1'b0;
                end else begin
                  ls_nxt = (in_data.byte_value == CH_NL);
                end
              end
              PH_HEADER: begin
                if (in_data.byte_value == CH_NL) begin
                  ph_nxt  = PH_SEQ;
                  seq_nxt = 32'd0;
                  ls_nxt  = 1'b1;
                end
              end
              PH_SEQ: begin
                if (in_data.byte_value == CH_NL) begin
                  if (seq_r == 32'd0) begin
                    ph_nxt        = PH_HALT;
                    od_nxt.status = STS_MALFORMED;
                  end else begin
                    ph_nxt = PH_PLUS;
                    ls_nxt = 1'b1;
                  end
                end else begin
                  cb_we   = seq_r < MAXL;
                  seq_nxt = sat_inc32(seq_r);
                  ls_nxt  = 1'b0;
                end
              end
              PH_PLUS: begin
                if (ls_r) begin
                  if (in_data.byte_value != CH_PLUS) begin
                    ph_nxt        = PH_HALT;
                    od_nxt.status = STS_MALFORMED;
                  end else begin
                    ls_nxt = 1'b0;
                  end
                end else if (in_data.byte_value == CH_NL) begin
                  ph_nxt = PH_QUAL;
                  ql_nxt = 32'd0;
                  ls_nxt = 1'b1;
                end
              end
              PH_QUAL: begin
                if (in_data.byte_value == CH_NL) begin
                  ls_nxt = 1'b1;
                  if (ql_r != seq_r) begin
                    ph_nxt        = PH_HALT;
                    od_nxt.status = STS_MALFORMED;
                  end else begin
                    ph_nxt = PH_SEEK;
                    if (ncalc == 32'd0) begin
                      rec_nxt             = sat_inc32(rec_r);
                      od_nxt.status       = STS_COMMIT;
                      od_nxt.record_count = sat_inc32(rec_r);
                    end else begin
                      ov_nxt  = 1'b0;
                      n_nxt   = ncalc[LW-1:0];
                      idx_nxt = '0;
                      st_nxt  = ST_WALK;
                    end
                  end
                end else begin
                  qb_we  = ql_r < MAXL;
                  buf_wa = ql_r[AW-1:0];
                  ql_nxt = sat_inc32(ql_r);
                  ls_nxt = 1'b0;
                end
              end
              default: od_nxt.status = STS_IGNORED;
            endcase
          end
        end
      end
      ST_STAT: begin
        od_nxt.status       = STS_STAT;
        od_nxt.record_count = rec_r;
        od_nxt.stat_value   = 40'd0;
        if (pok_r) begin
          if (sel_r < SEL_QSUM) od_nxt.stat_value = {8'd0, row_q.cnt[sel_r]};
          else if (sel_r == SEL_QSUM) od_nxt.stat_value = row_q.qsum;
        end
        ov_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_WALK: begin
        rd_addr = idx_r[AW-1:0];
        wv_nxt  = 1'b1;
        wa_nxt  = idx_r[AW-1:0];
        idx_nxt = idx_r + LW'(1);
        if (idx_r == n_r - LW'(1)) st_nxt = ST_WLAST;
      end
      ST_WLAST: begin
        rec_nxt             = sat_inc32(rec_r);
        od_nxt.status       = STS_COMMIT;
        od_nxt.record_count = sat_inc32(rec_r);
        od_nxt.stat_value   = 40'd0;
        ov_nxt              = 1'b1;
        st_nxt              = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign mem_we = (st_r == ST_CLEAR) || wv_r;
  assign mem_wa = (st_r == ST_CLEAR) ? clr_r : wa_r;

  // statistics memory, read-modify-write
  always_ff @(posedge clk) begin
    if (mem_we) stat_mem[mem_wa] <= (st_r == ST_CLEAR) ? '0 : row_w;
    row_q <= stat_mem[rd_addr];
  end

  // staging buffers for the current record
  always_ff @(posedge clk) begin
    if (cb_we) cls_mem[buf_wa] <= classify(in_data.byte_value);
    if (qb_we) qb_mem[buf_wa] <= in_data.byte_value;
    cls_q <= cls_mem[rd_addr];
    qb_q  <= qb_mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alen_r  <= 11'd1024;
      limit_r <= 32'd0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ACTIVE_LEN) alen_r <= cfg_wdata[10:0];
      if (cfg_index == REG_REC_LIMIT) limit_r <= cfg_wdata;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      ph_r  <= PH_SEEK;
      ls_r  <= 1'b1;
      seq_r <= 32'd0;
      ql_r  <= 32'd0;
      rec_r <= 32'd0;
      idx_r <= '0;
      n_r   <= '0;
      clr_r <= '0;
      wv_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ph_r  <= ph_nxt;
      ls_r  <= ls_nxt;
      seq_r <= seq_nxt;
      ql_r  <= ql_nxt;
      rec_r <= rec_nxt;
      idx_r <= idx_nxt;
      n_r   <= n_nxt;
      clr_r <= clr_nxt;
      wv_r  <= wv_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wa_r  <= wa_nxt;
    sel_r <= sel_nxt;
    pok_r <= pok_nxt;
    od_r  <= od_nxt;
  end

endmodule

[src/fqps_checker.sv]
module fqps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input fqps_pkg::out_req_t out_data
);
  import fqps_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no new request while a result is stuck
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  // status code range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= STS_IGNORED)
    else $error("bad status");

  // only stat replies carry a value
  a_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STS_STAT |-> out_data.stat_value == 40'd0)
    else $error("value on non-stat result");

endmodule

bind fastq_record_position_stats fqps_checker u_fqps_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
